/* design/assert_macros.svh */
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define KNCP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kncp assertion failed");

// implication checked at every clock edge outside reset
`define KNCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kncp assertion failed");

`endif

/* design/kncp_pkg.sv */
// types and constants of the keyword and number command parser
package kncp_pkg;

  localparam int NUM_KW = 4;
  localparam int PH_W = 4;
  localparam int VAL_W = 32;

  // keyword order is the result priority: right, step, forward, turn
  localparam logic [NUM_KW-1:0][55:0] KW_TEXT = {
    56'("turn"), 56'("forward"), 56'("step"), 56'("right")
  };
  localparam logic [NUM_KW-1:0][2:0] KW_LEN = {3'd4, 3'd7, 3'd4, 3'd5};

  localparam logic [PH_W-1:0] PH_IDLE   = 4'd0;
  localparam logic [PH_W-1:0] PH_FIRST  = 4'd1;
  localparam logic [PH_W-1:0] PH_SIGN   = 4'd8;
  localparam logic [PH_W-1:0] PH_DIGITS = 4'd9;
  localparam logic [PH_W-1:0] PH_DONE   = 4'd10;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_RIGHT   = 3'd1,
    KIND_STEP    = 3'd2,
    KIND_FORWARD = 3'd3,
    KIND_TURN    = 3'd4
  } kncp_kind_e;

  // one classified byte
  typedef struct packed {
    logic [NUM_KW-1:0][7:0] hit;
    logic                   start;
    logic                   is_dec;
    logic                   is_plus;
    logic                   is_minus;
    logic [3:0]             digit;
    logic                   last;
  } kncp_item_t;

endpackage

/* design/kncp_front.sv */
// front end: accepts bytes and classifies them against the keyword text
module kncp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 full_i,
  output logic                 push_o,
  output kncp_pkg::kncp_item_t item_o
);

  logic start_q, start_d;
  logic is_sep;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  for (genvar k = 0; k < kncp_pkg::NUM_KW; k++) begin : g_kw
    for (genvar p = 0; p < 8; p++) begin : g_pos
      if (p < int'(kncp_pkg::KW_LEN[k])) begin : g_char
        localparam int Lsb = 8 * (int'(kncp_pkg::KW_LEN[k]) - 1 - p);
        assign item_o.hit[k][p] = (data_byte_i == kncp_pkg::KW_TEXT[k][Lsb +: 8]);
      end else begin : g_none
        assign item_o.hit[k][p] = 1'b0;
      end
    end
  end

  always_comb begin
    is_sep          = (data_byte_i == kncp_pkg::CH_PLUS) || (data_byte_i == kncp_pkg::CH_NUL);
    item_o.start    = start_q;
    item_o.is_dec   = data_byte_i inside {[kncp_pkg::CH_ZERO:kncp_pkg::CH_NINE]};
    item_o.is_plus  = (data_byte_i == kncp_pkg::CH_PLUS);
    item_o.is_minus = (data_byte_i == kncp_pkg::CH_MINUS);
    item_o.digit    = 4'(data_byte_i - kncp_pkg::CH_ZERO);
    item_o.last     = last_byte_i;
    start_d         = push_o ? (is_sep || last_byte_i) : start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else begin
      start_q <= start_d;
    end
  end

endmodule

/* design/kncp_fifo.sv */
// short queue of classified bytes between front and back end
module kncp_fifo #(
  parameter int Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kncp_pkg::kncp_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output kncp_pkg::kncp_item_t item_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  kncp_pkg::kncp_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/kncp_back.sv */
// back end: keyword matchers, number accumulators and result register
module kncp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  kncp_pkg::kncp_item_t               item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         keyword_kind_o,
  output logic signed [kncp_pkg::VAL_W-1:0]  number_value_o
);

  logic [kncp_pkg::PH_W-1:0]  phase_q [kncp_pkg::NUM_KW];
  logic [kncp_pkg::PH_W-1:0]  phase_d [kncp_pkg::NUM_KW];
  logic [kncp_pkg::VAL_W-1:0] acc_q   [kncp_pkg::NUM_KW];
  logic [kncp_pkg::VAL_W-1:0] acc_d   [kncp_pkg::NUM_KW];
  logic [kncp_pkg::NUM_KW-1:0] neg_q, neg_d, found_q, found_d;

  logic                       out_valid_q;
  logic [2:0]                 kind_q;
  logic [kncp_pkg::VAL_W-1:0] value_q;
  kncp_pkg::kncp_kind_e       sel_kind;
  logic [kncp_pkg::VAL_W-1:0] sel_value;
  logic                       take;

  assign take           = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o          = take;
  assign out_valid_o    = out_valid_q;
  assign keyword_kind_o = kind_q;
  assign number_value_o = value_q;

  for (genvar k = 0; k < kncp_pkg::NUM_KW; k++) begin : g_match
    localparam logic [kncp_pkg::PH_W-1:0] Len = {1'b0, kncp_pkg::KW_LEN[k]};
    logic                       moved;
    logic [kncp_pkg::PH_W-1:0]  ph_nx;
    logic [kncp_pkg::VAL_W-1:0] acc_nx;
    logic [kncp_pkg::VAL_W-1:0] dterm;
    logic                       neg_nx;
    logic                       found_nx;

    // the sign is folded into each digit so the stored value is already signed
    always_comb begin
      moved    = 1'b0;
      ph_nx    = phase_q[k];
      acc_nx   = acc_q[k];
      neg_nx   = neg_q[k];
      found_nx = found_q[k];
      dterm    = neg_q[k] ? (kncp_pkg::VAL_W'(0) - kncp_pkg::VAL_W'(item_i.digit))
                          : kncp_pkg::VAL_W'(item_i.digit);
      if (phase_q[k] == kncp_pkg::PH_DONE) begin
        moved = 1'b1;
      end else if (phase_q[k] != kncp_pkg::PH_IDLE && phase_q[k] < Len) begin
        if (item_i.hit[k][phase_q[k][2:0]]) begin
          ph_nx = phase_q[k] + kncp_pkg::PH_W'(1);
          moved = 1'b1;
        end
      end else if (phase_q[k] == Len) begin
        if (item_i.is_plus || item_i.is_minus) begin
          neg_nx = item_i.is_minus;
          ph_nx  = kncp_pkg::PH_SIGN;
          moved  = 1'b1;
        end else if (item_i.is_dec) begin
          acc_nx   = kncp_pkg::VAL_W'(item_i.digit);
          found_nx = 1'b1;
          ph_nx    = kncp_pkg::PH_DIGITS;
          moved    = 1'b1;
        end
      end else if (phase_q[k] == kncp_pkg::PH_SIGN) begin
        if (item_i.is_dec) begin
          acc_nx   = dterm;
          found_nx = 1'b1;
          ph_nx    = kncp_pkg::PH_DIGITS;
          moved    = 1'b1;
        end
      end else if (phase_q[k] == kncp_pkg::PH_DIGITS) begin
        if (item_i.is_dec) begin
          acc_nx = (acc_q[k] << 3) + (acc_q[k] << 1) + dterm;
        end else begin
          ph_nx = kncp_pkg::PH_DONE;
        end
        moved = 1'b1;
      end
      if (!moved) begin
        ph_nx  = (item_i.start && item_i.hit[k][0]) ? kncp_pkg::PH_FIRST : kncp_pkg::PH_IDLE;
        neg_nx = 1'b0;
        acc_nx = '0;
      end
    end

    assign phase_d[k] = ph_nx;
    assign acc_d[k]   = acc_nx;
    assign neg_d[k]   = neg_nx;
    assign found_d[k] = found_nx;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[k] <= kncp_pkg::PH_IDLE;
        neg_q[k]   <= 1'b0;
        found_q[k] <= 1'b0;
      end else if (take) begin
        if (item_i.last) begin
          phase_q[k] <= kncp_pkg::PH_IDLE;
          neg_q[k]   <= 1'b0;
          found_q[k] <= 1'b0;
        end else begin
          phase_q[k] <= phase_d[k];
          neg_q[k]   <= neg_d[k];
          found_q[k] <= found_d[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (take) begin
        acc_q[k] <= acc_d[k];
      end
    end
  end

  // lowest index wins
  always_comb begin
    sel_kind  = kncp_pkg::KIND_NONE;
    sel_value = '0;
    for (int k = kncp_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (found_d[k]) begin
        sel_kind  = kncp_pkg::kncp_kind_e'(3'(k + 1));
        sel_value = acc_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= take && item_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      kind_q  <= sel_kind;
      value_q <= sel_value;
    end
  end

endmodule

/* design/keyword_number_command_parser.sv */
// top level of the keyword and number command parser
//
// input channel: one message byte per transfer on data_byte_i, with
// last_byte_i high on the final byte. a transfer happens at a rising edge
// with in_valid_i high and in_stall_o low.
// output channel: one result per message, keyword_kind_o (0 none, 1 right,
// 2 step, 3 forward, 4 turn) and the signed number_value_o, transferred when
// out_valid_o is high and out_stall_i is low.
// throughput is one byte per cycle while nothing stalls; the front end
// classifies each byte into a queue of QueueDepth entries (two by default)
// and the back end updates the four matchers with each byte it takes.
// a result passes the queue and then the result register to out_valid_o.
// reset clears the queue, the matchers and the output register; the next
// byte begins a new message.
// while the receiver stalls a valid result, that result holds, the back end
// stops and the queue fills; in_stall_o rises once the queue is full.
module keyword_number_command_parser #(
  parameter int QueueDepth = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        keyword_kind_o,
  output logic signed [kncp_pkg::VAL_W-1:0] number_value_o
);

  kncp_pkg::kncp_item_t front_item, back_item;
  logic push, full, pop, q_valid;

  kncp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  kncp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  kncp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (back_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .keyword_kind_o (keyword_kind_o),
    .number_value_o (number_value_o)
  );

endmodule

/* design/kncp_checker.sv */
// port checker for the command parser and its bind
`include "assert_macros.svh"

module kncp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        keyword_kind_o,
  input logic signed [kncp_pkg::VAL_W-1:0] number_value_o
);

  // kind codes stop at turn
  `KNCP_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_o, keyword_kind_o <= kncp_pkg::KIND_TURN)

  // no keyword means a zero value
  `KNCP_ASSERT_IMP(a_none_zero, clk_i, rst_ni,
                   out_valid_o && keyword_kind_o == kncp_pkg::KIND_NONE, number_value_o == '0)

  // the queue drains while the result register is empty
  `KNCP_ASSERT_IMP(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // a stalled result holds
  `KNCP_ASSERT(a_result_holds, clk_i, rst_ni,
               out_valid_o && out_stall_i |=>
               out_valid_o && $stable(keyword_kind_o) && $stable(number_value_o))

endmodule

bind keyword_number_command_parser kncp_checker u_checker (.*);

/* tb/keyword_number_command_parser_checker.sv */
`timescale 1ns / 1ps
// checker that predicts and compares the command parser's results
module keyword_number_command_parser_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         keyword_kind_i,
  input  logic signed [31:0] number_value_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    kncp_pkg::kncp_kind_e kind;
    logic signed [31:0]   value;
  } command_t;

  string       keyword_text [kncp_pkg::NUM_KW] = '{"right", "step", "forward", "turn"};

  logic [3:0]  match_phase [kncp_pkg::NUM_KW];
  logic [31:0] match_value [kncp_pkg::NUM_KW];
  logic        match_negative [kncp_pkg::NUM_KW];
  logic        match_found [kncp_pkg::NUM_KW];
  logic        start_ok;
  command_t    expected_commands [$];

  function automatic logic is_decimal(logic [7:0] b);
    return b >= kncp_pkg::CH_ZERO && b <= kncp_pkg::CH_NINE;
  endfunction

  task automatic clear_matchers();
    for (int k = 0; k < kncp_pkg::NUM_KW; k++) begin
      match_phase[k] = kncp_pkg::PH_IDLE;
      match_value[k] = '0;
      match_negative[k] = 1'b0;
      match_found[k] = 1'b0;
    end
    start_ok = 1'b1;
  endtask

  task automatic advance_matcher(int k, logic [7:0] b);
    logic [3:0]  ph;
    logic [31:0] digit;
    int          len;
    logic        moved;
    ph = match_phase[k];
    len = keyword_text[k].len();
    digit = {24'd0, b - kncp_pkg::CH_ZERO};
    moved = 1'b0;
    if (ph == kncp_pkg::PH_DONE) return;
    if (ph >= 1 && ph < len) begin
      if (b == keyword_text[k][ph]) begin
        ph++;
        moved = 1'b1;
      end
    end else if (ph == len) begin
      if (b == kncp_pkg::CH_PLUS || b == kncp_pkg::CH_MINUS) begin
        match_negative[k] = (b == kncp_pkg::CH_MINUS);
        ph = kncp_pkg::PH_SIGN;
        moved = 1'b1;
      end else if (is_decimal(b)) begin
        match_value[k] = digit;
        match_found[k] = 1'b1;
        ph = kncp_pkg::PH_DIGITS;
        moved = 1'b1;
      end
    end else if (ph == kncp_pkg::PH_SIGN) begin
      if (is_decimal(b)) begin
        match_value[k] = digit;
        match_found[k] = 1'b1;
        ph = kncp_pkg::PH_DIGITS;
        moved = 1'b1;
      end
    end else if (ph == kncp_pkg::PH_DIGITS) begin
      if (is_decimal(b)) match_value[k] = match_value[k] * 32'd10 + digit;
      else ph = kncp_pkg::PH_DONE;
      moved = 1'b1;
    end
    // a broken candidate is retried as a new keyword start after a separator
    if (!moved) begin
      ph = kncp_pkg::PH_IDLE;
      match_negative[k] = 1'b0;
      match_value[k] = '0;
      if (start_ok && b == keyword_text[k][0]) ph = kncp_pkg::PH_FIRST;
    end
    match_phase[k] = ph;
  endtask

  task automatic take_byte(logic [7:0] b, logic last);
    command_t cmd;
    for (int k = 0; k < kncp_pkg::NUM_KW; k++) advance_matcher(k, b);
    start_ok = (b == kncp_pkg::CH_PLUS || b == kncp_pkg::CH_NUL);
    if (last) begin
      cmd.kind = kncp_pkg::KIND_NONE;
      cmd.value = '0;
      // walk down so the highest priority keyword wins
      for (int k = kncp_pkg::NUM_KW - 1; k >= 0; k--) begin
        if (match_found[k]) begin
          cmd.kind = kncp_pkg::kncp_kind_e'(3'(k + 1));
          cmd.value = match_negative[k] ? -match_value[k] : match_value[k];
        end
      end
      expected_commands.push_back(cmd);
      clear_matchers();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    command_t want;
    if (!rst_ni) begin
      clear_matchers();
      expected_commands.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_commands.size() == 0) begin
          $display("%0t: unexpected result transfer: kind %0d value %0d", $time,
                   keyword_kind_i, number_value_i);
          fail_count_o++;
        end else begin
          want = expected_commands.pop_front();
          if (keyword_kind_i !== want.kind) begin
            $display("%0t: keyword_kind mismatch: expected %0d, actual %0d", $time,
                     want.kind, keyword_kind_i);
            fail_count_o++;
          end
          if (number_value_i !== want.value) begin
            $display("%0t: number_value mismatch: expected %0d, actual %0d", $time,
                     want.value, number_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_byte(data_byte_i, last_byte_i);
    end
    pending_o = expected_commands.size();
  end

endmodule

/* tb/keyword_number_command_parser_test.sv */
`timescale 1ns / 1ps
// testbench top for the command parser: stimulus, idling and verdict
module keyword_number_command_parser_test;

  localparam int TotalBytes     = 440;
  localparam int CalmBytes      = 100;
  localparam int LongHoldCycles = 80;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         keyword_kind;
  logic signed [31:0] number_value;
  int                 fail_count;
  int                 pending;

  logic [7:0]         command_bytes [$];
  string              keyword_words [4] = '{"right", "step", "forward", "turn"};
  int                 sent_bytes = 0;
  logic               calm = 1'b0;
  logic               long_hold_req = 1'b0;

  keyword_number_command_parser i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .keyword_kind_o(keyword_kind),
    .number_value_o(number_value)
  );

  keyword_number_command_parser_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .keyword_kind_i(keyword_kind),
    .number_value_i(number_value),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) command_bytes.push_back(s[i]);
  endtask

  task automatic send_command();
    for (int i = 0; i < command_bytes.size(); i++) begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= command_bytes[i];
      last_byte <= (i == command_bytes.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sent_bytes++;
    end
    command_bytes.delete();
  endtask

  task automatic build_random_command();
    int         segs;
    int         len;
    int         digits;
    string      kw;
    logic [7:0] ch;
    // noise message
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 10)) command_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    segs = $urandom_range(1, 3);
    for (int s = 0; s < segs; s++) begin
      if (s > 0) begin
        command_bytes.push_back($urandom_range(0, 1) ? kncp_pkg::CH_PLUS : kncp_pkg::CH_NUL);
      end
      if ($urandom_range(0, 7) == 0) command_bytes.push_back(8'($urandom_range(0, 255)));
      kw = keyword_words[$urandom_range(0, 3)];
      len = kw.len();
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, kw.len() - 1);
      for (int i = 0; i < len; i++) begin
        ch = kw[i];
        if ($urandom_range(0, 19) == 0) ch = 8'($urandom_range(0, 255));
        command_bytes.push_back(ch);
      end
      case ($urandom_range(0, 3))
        0: command_bytes.push_back(kncp_pkg::CH_PLUS);
        1: command_bytes.push_back(kncp_pkg::CH_MINUS);
        default: ;
      endcase
      digits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
      repeat (digits) command_bytes.push_back(kncp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0) command_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // receiver side: random stall bursts and one long hold-off
  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single all-ones byte, no keyword
    command_bytes.push_back(8'hff);
    send_command();
    // two keywords, priority and negative sign
    add_text("turn1+right-2");
    send_command();
    // nul start, broken sign retried as a new keyword
    command_bytes.push_back(kncp_pkg::CH_NUL);
    add_text("step+forward9");
    send_command();
    // message shorter than the keyword
    add_text("rig");
    send_command();

    long_hold_req = 1'b1;
    while (sent_bytes < TotalBytes) begin
      calm = (sent_bytes >= TotalBytes - CalmBytes);
      build_random_command();
      send_command();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
